### rtl/kwb_pkg.sv
// ----------------------------------------------------------------------------
// kwb_pkg - shared definitions for the K-weighting biquad cascade
// Widths, fixed-point formats, coefficient reset values and the control
// word layout that the microcode sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package kwb_pkg;

	// Field and arithmetic widths
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 28;
	localparam int STATE_BITS     = 40;
	localparam int COEF_BITS      = 32;
	localparam int OUT_BITS       = 18;
	localparam int NUM_COEFS      = 7;
	localparam int CFG_IDX_BITS   = 3;

	// Fraction bits of internal signals, clamped to [0, COEF_FRAC_BITS]
	localparam int SF_RAW   = STATE_BITS - SAMPLE_BITS - 5;
	localparam int SIG_FRAC = (SF_RAW < 0) ? 0 :
		((SF_RAW > COEF_FRAC_BITS) ? COEF_FRAC_BITS : SF_RAW);

	// Accumulator holds up to three saturated terms plus a doubled one
	localparam int ACC_BITS  = STATE_BITS + 3;
	// Signal magnitude goes through the multiplier in two halves
	localparam int HALF_BITS = (STATE_BITS + 1) / 2;
	localparam int PP_BITS   = COEF_BITS + HALF_BITS;
	localparam int PROD_BITS = COEF_BITS + STATE_BITS;

	// Microprogram length and step counter width
	localparam int NUM_STEPS = 30;
	localparam int PC_BITS   = $clog2(NUM_STEPS);

	typedef logic [COEF_BITS-1:0]       coef_t;
	typedef coef_t [NUM_COEFS-1:0]      coef_bank_t;

	// Coefficient select; values equal the configuration register index
	typedef enum logic [CFG_IDX_BITS-1:0] {
		COEF_SHELF_B0 = 3'd0,
		COEF_SHELF_B1 = 3'd1,
		COEF_SHELF_B2 = 3'd2,
		COEF_SHELF_A1 = 3'd3,
		COEF_SHELF_A2 = 3'd4,
		COEF_HP_A1    = 3'd5,
		COEF_HP_A2    = 3'd6
	} coef_sel_t;

	localparam coef_bank_t COEF_RESET = '{
		0: COEF_BITS'(412081942),
		1: COEF_BITS'(-722546694),
		2: COEF_BITS'(321691121),
		3: COEF_BITS'(-453832898),
		4: COEF_BITS'(196623811),
		5: COEF_BITS'(-534199296),
		6: COEF_BITS'(265770496)
	};

	typedef enum logic [1:0] {
		SIG_XS,
		SIG_Y1,
		SIG_Y2
	} sig_sel_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		SRC_TERM,
		SRC_D1,
		SRC_D2,
		SRC_H1,
		SRC_H2,
		SRC_Y1,
		SRC_Y1_M2
	} acc_src_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_Y1,
		WR_Y2,
		WR_D1,
		WR_D2,
		WR_H1,
		WR_H2
	} wr_dst_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ITEM,
		COND_OUT_BUSY
	} cond_t;

	// One microcode word
	typedef struct packed {
		logic               take;    // step accepts an input item
		logic               ld;      // load multiplier operands
		coef_sel_t          coef;
		sig_sel_t           sig;
		mul_op_t            mul;
		logic               rnd;     // round and cap the finished product
		acc_op_t            acc;
		acc_src_t           src;
		wr_dst_t            wr;
		logic               out;     // load the result register
		cond_t              cond;
		logic [PC_BITS-1:0] target;
	} kwb_ctl_t;

	// Status fed back to the sequencer for its jump conditions
	typedef struct packed {
		logic item_take;
		logic out_busy;
	} kwb_status_t;

endpackage

### rtl/kwb_useq.sv
// ----------------------------------------------------------------------------
// kwb_useq - microcode sequencer
// Step counter plus a read-only program; each step issues one control word
// and may jump on a condition from the handshake side.
// ----------------------------------------------------------------------------
module kwb_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kwb_pkg::kwb_status_t status,
	output kwb_pkg::kwb_ctl_t    ctl
);
	import kwb_pkg::*;

	localparam logic [PC_BITS-1:0] STEP_IDLE = '0;
	localparam logic [PC_BITS-1:0] STEP_OUT  = PC_BITS'(28);

	logic [PC_BITS-1:0] pc_q;
	logic               jump;

	// Program: shelf stage, then high-pass stage, then hand off the result
	function automatic kwb_ctl_t rom_word(input logic [PC_BITS-1:0] pc);
		kwb_ctl_t w;
		w = '{take: 1'b0, ld: 1'b0, coef: COEF_SHELF_B0, sig: SIG_XS, mul: MUL_NONE,
			rnd: 1'b0, acc: ACC_NONE, src: SRC_TERM, wr: WR_NONE, out: 1'b0,
			cond: COND_NEVER, target: STEP_IDLE};
		unique case (pc)
			0: begin
				w.take = 1'b1; w.cond = COND_NO_ITEM; w.target = STEP_IDLE;
			end
			1: begin
				w.ld = 1'b1; w.coef = COEF_SHELF_B0; w.sig = SIG_XS;
			end
			2: w.mul = MUL_LO;
			3: begin
				w.mul = MUL_HI; w.ld = 1'b1; w.coef = COEF_SHELF_B1; w.sig = SIG_XS;
			end
			4: begin
				w.rnd = 1'b1; w.mul = MUL_LO;
			end
			5: begin
				w.acc = ACC_LOAD; w.src = SRC_TERM; w.mul = MUL_HI;
			end
			6: begin
				w.acc = ACC_ADD; w.src = SRC_D1; w.rnd = 1'b1;
			end
			7: begin
				w.wr = WR_Y1; w.acc = ACC_LOAD; w.src = SRC_TERM;
			end
			8: begin
				w.acc = ACC_ADD; w.src = SRC_D2;
				w.ld = 1'b1; w.coef = COEF_SHELF_A1; w.sig = SIG_Y1;
			end
			9: w.mul = MUL_LO;
			10: begin
				w.mul = MUL_HI; w.ld = 1'b1; w.coef = COEF_SHELF_B2; w.sig = SIG_XS;
			end
			11: begin
				w.rnd = 1'b1; w.mul = MUL_LO;
			end
			12: begin
				w.acc = ACC_SUB; w.src = SRC_TERM; w.mul = MUL_HI;
			end
			13: begin
				w.wr = WR_D1; w.rnd = 1'b1;
				w.ld = 1'b1; w.coef = COEF_SHELF_A2; w.sig = SIG_Y1;
			end
			14: begin
				w.acc = ACC_LOAD; w.src = SRC_TERM; w.mul = MUL_LO;
			end
			15: w.mul = MUL_HI;
			16: w.rnd = 1'b1;
			17: begin
				w.acc = ACC_SUB; w.src = SRC_TERM;
			end
			18: begin
				w.wr = WR_D2; w.acc = ACC_LOAD; w.src = SRC_Y1;
			end
			19: begin
				w.acc = ACC_ADD; w.src = SRC_H1;
			end
			20: begin
				w.wr = WR_Y2; w.acc = ACC_LOAD; w.src = SRC_Y1_M2;
			end
			21: begin
				w.acc = ACC_ADD; w.src = SRC_H2;
				w.ld = 1'b1; w.coef = COEF_HP_A1; w.sig = SIG_Y2;
			end
			22: w.mul = MUL_LO;
			23: begin
				w.mul = MUL_HI; w.ld = 1'b1; w.coef = COEF_HP_A2; w.sig = SIG_Y2;
			end
			24: begin
				w.rnd = 1'b1; w.mul = MUL_LO;
			end
			25: begin
				w.acc = ACC_SUB; w.src = SRC_TERM; w.mul = MUL_HI;
			end
			26: begin
				w.wr = WR_H1; w.acc = ACC_LOAD; w.src = SRC_Y1; w.rnd = 1'b1;
			end
			27: begin
				w.acc = ACC_SUB; w.src = SRC_TERM;
			end
			28: begin
				w.out = 1'b1; w.cond = COND_OUT_BUSY; w.target = STEP_OUT;
			end
			29: begin
				w.wr = WR_H2; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctl = rom_word(pc_q);

	// Evaluate the jump condition of the current step
	always_comb begin
		unique case (ctl.cond)
			COND_NEVER:    jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NO_ITEM:  jump = !status.item_take;
			COND_OUT_BUSY: jump = status.out_busy;
			default:       jump = 1'b1;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### rtl/kwb_datapath.sv
// ----------------------------------------------------------------------------
// kwb_datapath - shared multiplier, accumulator and filter registers
// One coefficient-by-signal product goes through a single multiplier in two
// halves, is rounded and capped, then summed into the accumulator; sums are
// saturated when written back to the signal and delay registers.
// ----------------------------------------------------------------------------
module kwb_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kwb_pkg::kwb_ctl_t               ctl,
	input  logic                            item_take,
	input  logic [kwb_pkg::SAMPLE_BITS-1:0] sample_in,
	input  kwb_pkg::coef_bank_t             coefs,
	output logic [kwb_pkg::OUT_BITS-1:0]    result
);
	import kwb_pkg::*;

	typedef logic signed [STATE_BITS-1:0] sig_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;

	localparam int RQ_BITS = PROD_BITS - COEF_FRAC_BITS;
	localparam logic [PROD_BITS-1:0] RND_BIAS = PROD_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [RQ_BITS-1:0]   CAP_Q    = RQ_BITS'(1) << (STATE_BITS - 1);
	localparam logic signed [STATE_BITS:0] OUT_BIAS = (SIG_FRAC > 0) ?
		((STATE_BITS + 1)'(1) << (SIG_FRAC - 1)) : '0;

	sig_t xs_q, y1_q, y2_q;
	sig_t shelf_delay_one_q, shelf_delay_two_q;
	sig_t highpass_delay_one_q, highpass_delay_two_q;

	logic [COEF_BITS-1:0]        opc_q;
	logic [STATE_BITS-1:0]       ops_q;
	logic                        neg_q, negp_q;
	logic [PROD_BITS-1:0]        prod_q;
	logic signed [STATE_BITS:0]  term_q;
	acc_t                        acc_q;

	coef_t                       coef_sel;
	sig_t                        sig_sel;
	logic [COEF_BITS-1:0]        coef_mag;
	logic [STATE_BITS-1:0]       sig_mag;
	logic [HALF_BITS-1:0]        half;
	logic [PP_BITS-1:0]          pp;
	logic [PROD_BITS-1:0]        rsum;
	logic [RQ_BITS-1:0]          rq;
	logic [STATE_BITS-1:0]       mag;
	logic signed [STATE_BITS:0]  mag_ext;
	logic signed [STATE_BITS:0]  term_next;
	acc_t                        src_val;
	sig_t                        acc_sat;
	logic signed [STATE_BITS:0]  y2_biased;
	logic signed [STATE_BITS:0]  y2_shift;
	logic [STATE_BITS-OUT_BITS+1:0] out_top;

	function automatic sig_t sat_state(input acc_t v);
		logic [ACC_BITS-STATE_BITS:0] top;
		top = v[ACC_BITS-1:STATE_BITS-1];
		if ((&top) || !(|top)) begin
			return v[STATE_BITS-1:0];
		end else if (v[ACC_BITS-1]) begin
			return {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	endfunction

	// Pick operands and take magnitudes
	always_comb begin
		coef_sel = coefs[ctl.coef];
		case (ctl.sig)
			SIG_Y1:  sig_sel = y1_q;
			SIG_Y2:  sig_sel = y2_q;
			default: sig_sel = xs_q;
		endcase
		coef_mag = coef_sel[COEF_BITS-1] ? (~coef_sel + 1'b1) : coef_sel;
		sig_mag  = sig_sel[STATE_BITS-1] ? (~sig_sel + 1'b1) : sig_sel;
	end

	// Shared multiplier: one half of the signal magnitude per pass
	assign half = (ctl.mul == MUL_HI) ? HALF_BITS'(ops_q[STATE_BITS-1:HALF_BITS])
		: ops_q[HALF_BITS-1:0];
	assign pp = opc_q * half;

	// Round half away from zero, cap the magnitude, restore the sign
	always_comb begin
		rsum      = prod_q + RND_BIAS;
		rq        = rsum[PROD_BITS-1:COEF_FRAC_BITS];
		mag       = (rq > CAP_Q) ? STATE_BITS'(CAP_Q) : STATE_BITS'(rq);
		mag_ext   = {1'b0, mag};
		term_next = negp_q ? -mag_ext : mag_ext;
	end

	// Accumulator operand
	always_comb begin
		case (ctl.src)
			SRC_TERM:  src_val = ACC_BITS'(term_q);
			SRC_D1:    src_val = ACC_BITS'(shelf_delay_one_q);
			SRC_D2:    src_val = ACC_BITS'(shelf_delay_two_q);
			SRC_H1:    src_val = ACC_BITS'(highpass_delay_one_q);
			SRC_H2:    src_val = ACC_BITS'(highpass_delay_two_q);
			SRC_Y1:    src_val = ACC_BITS'(y1_q);
			SRC_Y1_M2: src_val = -(ACC_BITS'(y1_q) <<< 1);
			default:   src_val = '0;
		endcase
		acc_sat = sat_state(acc_q);
	end

	// Scale the high-pass output back to input scale and saturate
	always_comb begin
		y2_biased = (STATE_BITS + 1)'(y2_q) + OUT_BIAS;
		y2_shift  = y2_biased >>> SIG_FRAC;
		out_top   = y2_shift[STATE_BITS:OUT_BITS-1];
		if ((&out_top) || !(|out_top)) begin
			result = y2_shift[OUT_BITS-1:0];
		end else if (y2_shift[STATE_BITS]) begin
			result = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(OUT_BITS-1){1'b1}}};
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (item_take) begin
			xs_q <= sig_t'($signed(sample_in)) <<< SIG_FRAC;
		end
		if (ctl.ld) begin
			opc_q <= coef_mag;
			ops_q <= sig_mag;
			neg_q <= coef_sel[COEF_BITS-1] ^ sig_sel[STATE_BITS-1];
		end
		case (ctl.mul)
			MUL_LO: prod_q <= PROD_BITS'(pp);
			MUL_HI: begin
				prod_q <= prod_q + (PROD_BITS'(pp) << HALF_BITS);
				negp_q <= neg_q;
			end
			default: ;
		endcase
		if (ctl.rnd) begin
			term_q <= term_next;
		end
		case (ctl.acc)
			ACC_LOAD: acc_q <= src_val;
			ACC_ADD:  acc_q <= acc_q + src_val;
			ACC_SUB:  acc_q <= acc_q - src_val;
			default:  ;
		endcase
		case (ctl.wr)
			WR_Y1:   y1_q <= acc_sat;
			WR_Y2:   y2_q <= acc_sat;
			default: ;
		endcase
	end

	// Filter delays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shelf_delay_one_q    <= '0;
			shelf_delay_two_q    <= '0;
			highpass_delay_one_q <= '0;
			highpass_delay_two_q <= '0;
		end else begin
			case (ctl.wr)
				WR_D1:   shelf_delay_one_q    <= acc_sat;
				WR_D2:   shelf_delay_two_q    <= acc_sat;
				WR_H1:   highpass_delay_one_q <= acc_sat;
				WR_H2:   highpass_delay_two_q <= acc_sat;
				default: ;
			endcase
		end
	end

endmodule

### rtl/k_weighting_biquad_cascade.sv
// ----------------------------------------------------------------------------
// k_weighting_biquad_cascade - K-weighting pre-filter, one audio channel
// High-shelf biquad followed by a high-pass biquad, fixed point, run by a
// microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted sample occupies the block while the microprogram runs the
// steps after its accept step; the seven coefficient products each go in
// two halves through the one 32-bit by 20-bit multiplier. The result is
// held in an output register, so the next sample is accepted while it
// waits; if it is still held when the next result is ready, the program
// waits at its output step. Coefficients are written through the cfg port,
// index 0..6, in Q3.28; writes to index 7 are ignored. Write them only
// while no sample is in flight.
module k_weighting_biquad_cascade (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kwb_pkg::SAMPLE_BITS-1:0]  sample_in,
	input  logic                             end_of_block,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [kwb_pkg::OUT_BITS-1:0]     sample_out,
	output logic                             end_of_block_out,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kwb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [kwb_pkg::COEF_BITS-1:0]    cfg_data
);
	import kwb_pkg::*;

	kwb_ctl_t              ctl;
	kwb_status_t           status;
	coef_bank_t            coef_q;
	logic                  eob_q;
	logic [OUT_BITS-1:0]   result;
	logic                  item_take;
	logic                  out_busy;
	logic                  out_load;

	// Handshake decode
	assign in_stall  = !ctl.take;
	assign item_take = in_valid && ctl.take;
	assign out_busy  = out_valid && out_stall;
	assign out_load  = ctl.out && !out_busy;
	assign cfg_ready = 1'b1;
	assign status    = '{item_take: item_take, out_busy: out_busy};

	kwb_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	kwb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item_take (item_take),
		.sample_in (sample_in),
		.coefs     (coef_q),
		.result    (result)
	);

	// Coefficient registers; drop writes beyond the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index < NUM_COEFS)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Hold the flag of the item in flight
	always_ff @(posedge clk) begin
		if (item_take) begin
			eob_q <= end_of_block;
		end
	end

	// Output register: load a finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out       <= result;
			end_of_block_out <= eob_q;
		end
	end

endmodule

### rtl/kwb_checker.sv
// ----------------------------------------------------------------------------
// kwb_checker - port-level checks for the K-weighting biquad cascade
// Watches the handshakes of the top level and flags behavior that the
// sequencer and output register must never show.
// ----------------------------------------------------------------------------
module kwb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [kwb_pkg::OUT_BITS-1:0]     sample_out,
	input logic                             end_of_block_out
);

	// A held result stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sample_out) && $stable(end_of_block_out))
		else $error("result payload changed while stalled");

	// An accepted item keeps the input side busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken right after an accept");

	// A new result only appears while an item is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced with no item in flight");

endmodule

bind k_weighting_biquad_cascade kwb_checker u_kwb_checker (.*);
